FILE: hw/rtl/bfe_pkg.sv
// shared types and constants of the boundary fill engine
package bfe_pkg;

	localparam int COLOR_W = 24;
	localparam int COUNT_W = 13;
	localparam int CMD_W   = 2;
	localparam int COORD_W = 6;

	localparam logic [COLOR_W-1:0] COLOR_WHITE  = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] FILL_RESET   = 24'hFF0000;
	localparam logic [COLOR_W-1:0] BORDER_RESET = 24'h0000FF;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 13'h1FFF;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

	localparam logic REG_FILL_COLOR   = 1'b0;
	localparam logic REG_BORDER_COLOR = 1'b1;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

endpackage

FILE: hw/rtl/bfe_frame_mem.sv
// frame store memory with a white clearing sweep after reset
module bfe_frame_mem #(
	parameter int AW = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bfe_pkg::mem_ctl_t          ctl,
	input  logic [AW-1:0]              addr,
	input  logic [bfe_pkg::COLOR_W-1:0] wdata,
	output logic [bfe_pkg::COLOR_W-1:0] rdata,
	output logic                       clear_busy
);
	import bfe_pkg::*;

	logic [COLOR_W-1:0] mem [2**AW];
	logic [COLOR_W-1:0] rdata_q;
	logic [AW-1:0]      clr_addr_q;
	logic               clr_busy_q;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [COLOR_W-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}})
				clr_busy_q <= 1'b0;
		end
	end

	// the sweep owns the write port until it finishes
	always_comb begin
		wr_en   = clr_busy_q | ctl.wr;
		wr_addr = clr_busy_q ? clr_addr_q : addr;
		wr_data = clr_busy_q ? COLOR_WHITE : wdata;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (ctl.rd)
			rdata_q <= mem[addr];
	end

	assign rdata      = rdata_q;
	assign clear_busy = clr_busy_q;

endmodule

FILE: hw/rtl/bfe_coord_stack.sv
// coordinate stack memory of the fill walk
module bfe_coord_stack #(
	parameter int AW = 12
) (
	input  logic              clk,
	input  bfe_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     waddr,
	input  logic [AW-1:0]     wdata,
	input  logic [AW-1:0]     raddr,
	output logic [AW-1:0]     rdata
);
	import bfe_pkg::*;

	logic [AW-1:0] mem [2**AW];
	logic [AW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr)
			mem[waddr] <= wdata;
		if (ctl.rd)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bfe_nbr_unit.sv
// shared step unit: neighbour coordinate, frame bound test and colour compare
module bfe_nbr_unit #(
	parameter int FRAME_WIDTH  = 64,
	parameter int FRAME_HEIGHT = 64,
	parameter int XW           = 6,
	parameter int YW           = 6
) (
	input  logic [XW-1:0]               cur_x,
	input  logic [YW-1:0]               cur_y,
	input  bfe_pkg::dir_t               dir,
	input  logic [bfe_pkg::COLOR_W-1:0] pixel,
	input  logic [bfe_pkg::COLOR_W-1:0] fill_color,
	input  logic [bfe_pkg::COLOR_W-1:0] border_color,
	output logic [XW-1:0]               nbr_x,
	output logic [YW-1:0]               nbr_y,
	output logic                        nbr_ok,
	output logic                        paintable
);
	import bfe_pkg::*;

	logic [XW:0] x_inc;
	logic [YW:0] y_inc;

	always_comb begin
		x_inc  = {1'b0, cur_x} + (XW+1)'(1);
		y_inc  = {1'b0, cur_y} + (YW+1)'(1);
		nbr_x  = cur_x;
		nbr_y  = cur_y;
		nbr_ok = 1'b0;
		case (dir)
			DIR_RIGHT: begin
				nbr_x  = x_inc[XW-1:0];
				nbr_ok = x_inc < (XW+1)'(FRAME_WIDTH);
			end
			DIR_LEFT: begin
				nbr_x  = cur_x - XW'(1);
				nbr_ok = cur_x != '0;
			end
			DIR_DOWN: begin
				nbr_y  = y_inc[YW-1:0];
				nbr_ok = y_inc < (YW+1)'(FRAME_HEIGHT);
			end
			DIR_UP: begin
				nbr_y  = cur_y - YW'(1);
				nbr_ok = cur_y != '0;
			end
			default: begin
				nbr_ok = 1'b0;
			end
		endcase
		paintable = (pixel != border_color) && (pixel != fill_color);
	end

endmodule

FILE: hw/rtl/boundary_fill_engine.sv
// top level: command sequencer of the boundary fill engine
//
//  channel  direction  handshake          payload
//  in       to block   in_valid/in_stall  command, x_coord, y_coord, pixel_color
//  out      from block out_valid/out_stall read_color, painted_count
//  cfg      to block   cfg_we             cfg_index, cfg_data
//
// write passes through the response state, read through the read and response states,
// each ending in the output register; fill checks the seed, then for each painted
// pixel pops it and loads it from the stack and steps through its four neighbours,
// testing each one inside the frame through the single frame store read port
// after reset the frame store is swept white over all 2**(clog2(W)+clog2(H))
// addresses (4096 at 64 x 64), with in_stall high
// a new item is taken while a result waits; the block holds its result until
// the output register is free
module boundary_fill_engine #(
	parameter int FRAME_WIDTH  = 64,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bfe_pkg::CMD_W-1:0]    command,
	input  logic [bfe_pkg::COORD_W-1:0]  x_coord,
	input  logic [bfe_pkg::COORD_W-1:0]  y_coord,
	input  logic [bfe_pkg::COLOR_W-1:0]  pixel_color,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bfe_pkg::COLOR_W-1:0]  read_color,
	output logic [bfe_pkg::COUNT_W-1:0]  painted_count,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bfe_pkg::COLOR_W-1:0]  cfg_data
);
	import bfe_pkg::*;

	localparam int XW     = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
	localparam int YW     = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
	localparam int AW     = XW + YW;
	localparam int SPW    = AW + 1;
	localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_POP   = 7'b0001000,
		S_LOAD  = 7'b0010000,
		S_NBR   = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [COLOR_W-1:0] fill_q;
	logic [COLOR_W-1:0] border_q;
	logic [XW-1:0]      cur_x_q;
	logic [YW-1:0]      cur_y_q;
	logic [XW-1:0]      cand_x_q;
	logic [YW-1:0]      cand_y_q;
	dir_t               dir_q;
	logic               seed_q;
	logic [SPW-1:0]     sp_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COLOR_W-1:0] res_color_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               out_valid_q;
	logic [COLOR_W-1:0] read_color_q;
	logic [COUNT_W-1:0] painted_count_q;

	logic               in_accept;
	logic               in_frame;
	logic [XW-1:0]      x_in;
	logic [YW-1:0]      y_in;
	logic               clear_busy;
	logic               out_free;
	logic [SPW-1:0]     sp_dec;

	mem_ctl_t           frame_ctl;
	logic [AW-1:0]      frame_addr;
	logic [COLOR_W-1:0] frame_wdata;
	logic [COLOR_W-1:0] frame_rdata;

	mem_ctl_t           stack_ctl;
	logic [AW-1:0]      stack_rdata;

	logic [XW-1:0]      nbr_x;
	logic [YW-1:0]      nbr_y;
	logic               nbr_ok;
	logic               paintable;

	assign in_stall  = (state_q != S_IDLE) || clear_busy;
	assign in_accept = in_valid && !in_stall;
	assign in_frame  = (32'(x_coord) < 32'(FRAME_WIDTH)) && (32'(y_coord) < 32'(FRAME_HEIGHT));
	assign x_in      = XW'(x_coord);
	assign y_in      = YW'(y_coord);
	assign out_free  = !out_valid_q || !out_stall;
	assign sp_dec    = sp_q - SPW'(1);

	bfe_frame_mem #(.AW(AW)) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (frame_ctl),
		.addr       (frame_addr),
		.wdata      (frame_wdata),
		.rdata      (frame_rdata),
		.clear_busy (clear_busy)
	);

	bfe_coord_stack #(.AW(AW)) u_stack (
		.clk   (clk),
		.ctl   (stack_ctl),
		.waddr (sp_q[AW-1:0]),
		.wdata ({cand_y_q, cand_x_q}),
		.raddr (sp_dec[AW-1:0]),
		.rdata (stack_rdata)
	);

	bfe_nbr_unit #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.XW           (XW),
		.YW           (YW)
	) u_nbr (
		.cur_x        (cur_x_q),
		.cur_y        (cur_y_q),
		.dir          (dir_q),
		.pixel        (frame_rdata),
		.fill_color   (fill_q),
		.border_color (border_q),
		.nbr_x        (nbr_x),
		.nbr_y        (nbr_y),
		.nbr_ok       (nbr_ok),
		.paintable    (paintable)
	);

	// frame and stack port selection per state
	always_comb begin
		frame_ctl   = '0;
		frame_addr  = {y_in, x_in};
		frame_wdata = pixel_color;
		stack_ctl   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_accept && in_frame) begin
					frame_ctl.wr = command == CMD_WRITE;
					frame_ctl.rd = (command == CMD_READ) || (command == CMD_FILL);
				end
			end
			S_NBR: begin
				frame_addr   = {nbr_y, nbr_x};
				frame_ctl.rd = nbr_ok;
			end
			S_CHECK: begin
				frame_addr   = {cand_y_q, cand_x_q};
				frame_wdata  = fill_q;
				frame_ctl.wr = paintable;
				stack_ctl.wr = paintable;
			end
			S_POP: begin
				stack_ctl.rd = sp_q != '0;
			end
			default: begin
				frame_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= FILL_RESET;
			border_q <= BORDER_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_FILL_COLOR)
				fill_q <= cfg_data;
			else
				border_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dir_q       <= DIR_RIGHT;
			seed_q      <= 1'b0;
			sp_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						res_color_q <= '0;
						res_count_q <= '0;
						cand_x_q    <= x_in;
						cand_y_q    <= y_in;
						state_q     <= S_RESP;
						if (in_frame && command == CMD_READ) begin
							state_q <= S_READ;
						end else if (in_frame && command == CMD_FILL) begin
							sp_q    <= '0;
							cnt_q   <= '0;
							seed_q  <= 1'b1;
							state_q <= S_CHECK;
						end
					end
				end
				S_READ: begin
					res_color_q <= frame_rdata;
					state_q     <= S_RESP;
				end
				S_CHECK: begin
					if (paintable) begin
						sp_q <= sp_q + SPW'(1);
						if (cnt_q != COUNT_MAX)
							cnt_q <= cnt_q + COUNT_W'(1);
					end
					if (seed_q || dir_q == DIR_UP) begin
						seed_q  <= 1'b0;
						state_q <= S_POP;
					end else begin
						dir_q   <= dir_t'(dir_q + 2'd1);
						state_q <= S_NBR;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						res_count_q <= cnt_q;
						state_q     <= S_RESP;
					end else begin
						sp_q    <= sp_dec;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cur_x_q <= stack_rdata[XW-1:0];
					cur_y_q <= stack_rdata[AW-1:XW];
					dir_q   <= DIR_RIGHT;
					state_q <= S_NBR;
				end
				S_NBR: begin
					if (nbr_ok) begin
						cand_x_q <= nbr_x;
						cand_y_q <= nbr_y;
						state_q  <= S_CHECK;
					end else if (dir_q == DIR_UP) begin
						state_q <= S_POP;
					end else begin
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						read_color_q    <= res_color_q;
						painted_count_q <= res_count_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign read_color    = read_color_q;
	assign painted_count = painted_count_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= PIXELS)
		else $error("coordinate stack pointer beyond frame size");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result shown without passing the response state");

	a_load_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> $past(state_q == S_POP) && $past(sp_q != '0))
		else $error("stack load without a pop");

	a_idle_when_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> state_q == S_IDLE)
		else $error("item in work during the frame clearing sweep");

endmodule
